// ===== hdl/sptd_pkg.sv =====
// Shared types, constants and codes of the spike threshold detector.
// Used by the channel interfaces and by every module of the block; depends on nothing.
package sptd_pkg;

   // Channel count and field widths.
   localparam int CHANNELS    = 64;
   localparam int CH_W        = 6;
   localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SAMPLE_W    = 16;
   localparam int TIME_W      = 32;
   localparam int THR_W       = 31;
   localparam int MASK_W      = 64;
   localparam int Y2_W        = 31;
   localparam int CMP_W       = 34;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [CH_W:0]       CHANNELS_EXT = (CH_W + 1)'(CHANNELS);
   localparam logic [THR_W-1:0]    THR_MAX      = {THR_W{1'b1}};
   localparam logic [MASK_W-1:0]   MASK_RESET   = {MASK_W{1'b1}};
   localparam logic [QCNT_W-1:0]   QUEUE_FULL   = QCNT_W'(QUEUE_DEPTH);

   // Operation codes of an input item.
   localparam logic OP_SAMPLE    = 1'b0;
   localparam logic OP_THRESHOLD = 1'b1;

   // Classification made by the front.
   typedef enum logic [1:0] {
      KIND_SAMPLE,
      KIND_THRESHOLD,
      KIND_IGNORE
   } kind_type;

   // Item as it travels through the queue.
   typedef struct packed {
      kind_type                   kind;
      logic [CH_W-1:0]            channel;
      logic signed [SAMPLE_W-1:0] sample_value;
      logic [TIME_W-1:0]          time_stamp;
      logic [THR_W-1:0]           threshold;
      logic [Y2_W-1:0]            y2;
   } qentry_type;

   // Per-channel state held in the back's memory.
   typedef struct packed {
      logic                       in_spike;
      logic                       negative;
      logic [TIME_W-1:0]          start_time;
      logic [TIME_W-1:0]          extreme_time;
      logic signed [SAMPLE_W-1:0] extreme_value;
      logic [THR_W-1:0]           threshold;
   } chan_state_type;

   localparam chan_state_type STATE_RESET = '{
      in_spike:      1'b0,
      negative:      1'b0,
      start_time:    '0,
      extreme_time:  '0,
      extreme_value: '0,
      threshold:     THR_MAX
   };

   // One spike record.
   typedef struct packed {
      logic [CH_W-1:0]            spike_channel;
      logic [TIME_W-1:0]          peak_time;
      logic [TIME_W-1:0]          spike_width;
      logic signed [SAMPLE_W-1:0] peak_height;
   } spike_rec_type;

endpackage

// ===== hdl/sptd_channels.sv =====
// Valid/ready channel interfaces of the spike threshold detector: request,
// response and register write. Depends on sptd_pkg for the field widths.
interface sptd_req_if;
   import sptd_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [CH_W-1:0]            channel;
   logic signed [SAMPLE_W-1:0] sample_value;
   logic [TIME_W-1:0]          time_stamp;
   logic [THR_W-1:0]           threshold_squared_in;

   modport source (output valid, output op, output channel, output sample_value,
                   output time_stamp, output threshold_squared_in, input ready);
   modport sink   (input valid, input op, input channel, input sample_value,
                   input time_stamp, input threshold_squared_in, output ready);
endinterface

interface sptd_rsp_if;
   import sptd_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CH_W-1:0]            spike_channel;
   logic [TIME_W-1:0]          peak_time;
   logic [TIME_W-1:0]          spike_width;
   logic signed [SAMPLE_W-1:0] peak_height;

   modport source (output valid, output spike_channel, output peak_time,
                   output spike_width, output peak_height, input ready);
   modport sink   (input valid, input spike_channel, input peak_time,
                   input spike_width, input peak_height, output ready);
endinterface

interface sptd_csr_if;
   import sptd_pkg::*;

   logic              valid;
   logic              ready;
   logic [MASK_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/sptd_front.sv =====
// Front of the spike threshold detector: accepts request items, classifies
// them and squares the sample. Depends on sptd_pkg and sptd_req_if.
module sptd_front (
   input  logic                clock,
   input  logic                reset,
   sptd_req_if.sink            req_chan,
   output logic                push_valid,
   output sptd_pkg::qentry_type push_data,
   input  logic                push_ready
);
   import sptd_pkg::*;

   logic                       front_valid_ff;
   logic                       front_valid_in;
   qentry_type                 front_item_ff;
   qentry_type                 front_item_in;
   kind_type                   kind_in;
   logic                       accept;
   logic                       advance;
   logic signed [2*SAMPLE_W-1:0] product;

   // The register moves on when its item enters the queue or is dropped.
   assign advance        = front_valid_ff &&
                           ((front_item_ff.kind == KIND_IGNORE) || push_ready);
   assign req_chan.ready = !front_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   // Classify the incoming item; channels past the last one are dropped.
   always_comb begin
      if ({1'b0, req_chan.channel} >= CHANNELS_EXT) begin
         kind_in = KIND_IGNORE;
      end else if (req_chan.op == OP_THRESHOLD) begin
         kind_in = KIND_THRESHOLD;
      end else begin
         kind_in = KIND_SAMPLE;
      end
   end

   always_comb begin
      front_item_in.kind         = kind_in;
      front_item_in.channel      = req_chan.channel;
      front_item_in.sample_value = req_chan.sample_value;
      front_item_in.time_stamp   = req_chan.time_stamp;
      front_item_in.threshold    = req_chan.threshold_squared_in;
      front_item_in.y2           = '0;
      front_valid_in             = accept || (front_valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_item_ff <= front_item_in;
      end
   end

   // Square of the sample; the queue register follows the multiplier.
   assign product = front_item_ff.sample_value * front_item_ff.sample_value;

   always_comb begin
      push_data    = front_item_ff;
      push_data.y2 = product[Y2_W-1:0];
      push_valid   = front_valid_ff && (front_item_ff.kind != KIND_IGNORE);
   end

endmodule

// ===== hdl/sptd_queue.sv =====
// Short register queue between the front and the back of the spike
// threshold detector. Depends on sptd_pkg.
module sptd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  sptd_pkg::qentry_type push_data,
   output logic                 push_ready,
   output logic                 pop_valid,
   output sptd_pkg::qentry_type pop_data,
   input  logic                 pop_ready
);
   import sptd_pkg::*;

   qentry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;
   logic               push;
   logic               pop;

   assign push_ready = (count_ff != QUEUE_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/sptd_back.sv =====
// Back of the spike threshold detector: per-channel state memory, the
// spike decision and the result register. Depends on sptd_pkg.
module sptd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   input  sptd_pkg::qentry_type     pop_data,
   output logic                     pop_ready,
   input  logic [sptd_pkg::MASK_W-1:0] report_mask,
   output logic                     rsp_valid,
   output sptd_pkg::spike_rec_type  rsp_rec,
   input  logic                     rsp_ready
);
   import sptd_pkg::*;

   chan_state_type     state_mem [CHANNELS];
   logic               entry_ok_ff [CHANNELS];

   logic               x_valid_ff;
   logic               x_valid_in;
   qentry_type         x_item_ff;
   chan_state_type     rd_data_ff;
   logic               rd_ok_ff;
   logic               byp_ff;
   logic               byp_in;
   chan_state_type     byp_data_ff;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   spike_rec_type      rsp_rec_ff;
   spike_rec_type      rsp_rec_in;

   chan_state_type     cur_state;
   chan_state_type     new_state;
   logic               emit;
   logic               extend;
   logic               x_adv;
   logic               pop;
   logic               out_free;
   logic [CMP_W-1:0]   y2_x10;
   logic [CMP_W-1:0]   thr_x7;
   logic [CH_IDX_W-1:0] x_idx;
   logic [CH_IDX_W-1:0] pop_idx;

   assign x_idx   = x_item_ff.channel[CH_IDX_W-1:0];
   assign pop_idx = pop_data.channel[CH_IDX_W-1:0];

   // The execute stage waits only when it has a record and the output is full.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign x_adv     = x_valid_ff && (!emit || out_free);
   assign pop_ready = !x_valid_ff || x_adv;
   assign pop       = pop_valid && pop_ready;

   // A write to the channel being read in the same cycle is forwarded.
   assign byp_in = x_adv && (x_idx == pop_idx);

   // Current state: forwarded, stored, or the reset entry if never written.
   always_comb begin
      if (byp_ff) begin
         cur_state = byp_data_ff;
      end else if (rd_ok_ff) begin
         cur_state = rd_data_ff;
      end else begin
         cur_state = STATE_RESET;
      end
   end

   // Hysteresis compare 10*y*y < 7*threshold, exact in integers.
   assign y2_x10 = (CMP_W'(x_item_ff.y2) << 3) + (CMP_W'(x_item_ff.y2) << 1);
   assign thr_x7 = (CMP_W'(cur_state.threshold) << 3) - CMP_W'(cur_state.threshold);

   // Threshold update, spike entry, peak tracking and spike end.
   always_comb begin
      new_state = cur_state;
      emit      = 1'b0;
      extend    = 1'b0;
      case (x_item_ff.kind)
         KIND_THRESHOLD: begin
            new_state.threshold = x_item_ff.threshold;
         end
         KIND_SAMPLE: begin
            if (!cur_state.in_spike) begin
               if (THR_W'(x_item_ff.y2) > cur_state.threshold) begin
                  new_state.in_spike      = 1'b1;
                  new_state.start_time    = x_item_ff.time_stamp;
                  new_state.extreme_time  = x_item_ff.time_stamp;
                  new_state.extreme_value = x_item_ff.sample_value;
                  new_state.negative      = x_item_ff.sample_value[SAMPLE_W-1];
               end
            end else begin
               if (cur_state.negative) begin
                  extend = (x_item_ff.sample_value < cur_state.extreme_value);
               end else begin
                  extend = (x_item_ff.sample_value > cur_state.extreme_value);
               end
               if (extend) begin
                  new_state.extreme_value = x_item_ff.sample_value;
                  new_state.extreme_time  = x_item_ff.time_stamp;
               end else if (y2_x10 < thr_x7) begin
                  new_state.in_spike = 1'b0;
                  emit = x_valid_ff && report_mask[x_item_ff.channel];
               end
            end
         end
         default: begin
            new_state = cur_state;
         end
      endcase
   end

   // Record built from the state before the spike ended.
   always_comb begin
      rsp_rec_in.spike_channel = x_item_ff.channel;
      rsp_rec_in.peak_time     = cur_state.extreme_time;
      rsp_rec_in.spike_width   = x_item_ff.time_stamp - cur_state.start_time;
      rsp_rec_in.peak_height   = cur_state.extreme_value;
   end

   always_comb begin
      x_valid_in = pop || (x_valid_ff && !x_adv);
      if (x_adv && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers and per-entry written flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_ff       <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            entry_ok_ff[i] <= 1'b0;
         end
      end else begin
         x_valid_ff   <= x_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            byp_ff <= byp_in;
         end
         if (x_adv) begin
            entry_ok_ff[x_idx] <= 1'b1;
         end
      end
   end

   // State memory: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (x_adv) begin
         state_mem[x_idx] <= new_state;
      end
      if (pop) begin
         rd_data_ff  <= state_mem[pop_idx];
         rd_ok_ff    <= entry_ok_ff[pop_idx];
         byp_data_ff <= new_state;
         x_item_ff   <= pop_data;
      end
   end

   always_ff @(posedge clock) begin
      if (x_adv && emit) begin
         rsp_rec_ff <= rsp_rec_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rec   = rsp_rec_ff;

endmodule

// ===== hdl/spike_threshold_detector.sv =====
// Top level of the multi-channel spike threshold detector with peak tracking.
// Depends on sptd_pkg, the sptd channel interfaces, sptd_front, sptd_queue and sptd_back.
//
//   Port       Direction  Carries
//   req_chan   in         op, channel, sample_value, time_stamp, threshold_squared_in
//   rsp_chan   out        spike_channel, peak_time, spike_width, peak_height
//   csr_chan   in         channel_report_mask write data (always ready)
//
// One item is accepted every cycle unless the response side stalls; the sample that
// ends a spike passes the front register, queue, execute stage and output register.
// The per-channel state is read, modified and written through a registered memory read
// with write forwarding, so samples of one channel may follow back to back.
// Reset clears the per-channel written flags at once; there is no clearing pass.
// A stalled response holds only an item that ends a spike; the queue absorbs the rest.
module spike_threshold_detector (
   input  logic       clock,
   input  logic       reset,
   sptd_req_if.sink   req_chan,
   sptd_rsp_if.source rsp_chan,
   sptd_csr_if.sink   csr_chan
);
   import sptd_pkg::*;

   logic              push_valid;
   logic              push_ready;
   qentry_type        push_data;
   logic              pop_valid;
   logic              pop_ready;
   qentry_type        pop_data;
   logic [MASK_W-1:0] mask_ff;
   logic [MASK_W-1:0] mask_in;
   logic              rsp_valid;
   spike_rec_type     rsp_rec;

   // Report mask register.
   assign csr_chan.ready = 1'b1;
   assign mask_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.data : mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
      end else begin
         mask_ff <= mask_in;
      end
   end

   sptd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   sptd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   sptd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_data    (pop_data),
      .pop_ready   (pop_ready),
      .report_mask (mask_ff),
      .rsp_valid   (rsp_valid),
      .rsp_rec     (rsp_rec),
      .rsp_ready   (rsp_chan.ready)
   );

   // Response channel.
   assign rsp_chan.valid         = rsp_valid;
   assign rsp_chan.spike_channel = rsp_rec.spike_channel;
   assign rsp_chan.peak_time     = rsp_rec.peak_time;
   assign rsp_chan.spike_width   = rsp_rec.spike_width;
   assign rsp_chan.peak_height   = rsp_rec.peak_height;

endmodule

// ===== bench/tb_spike_threshold_detector.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of spike_threshold_detector: directed and random items with
// a per-channel spike predictor. Depends on sptd_pkg, the sptd channel interfaces and the RTL.
module tb_spike_threshold_detector;
   import sptd_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 300000;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned PRESSURE_CYCLES = 400;

   // One input item as the driver offers it.
   typedef struct packed {
      logic                       op;
      logic [CH_W-1:0]            channel;
      logic signed [SAMPLE_W-1:0] sample_value;
      logic [TIME_W-1:0]          time_stamp;
      logic [THR_W-1:0]           threshold;
   } detector_item_type;

   logic clock = 1'b0;
   logic reset;

   sptd_req_if req_chan ();
   sptd_rsp_if rsp_chan ();
   sptd_csr_if csr_chan ();

   spike_threshold_detector dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predicted per-channel spike state and the report mask.
   logic                       chan_active     [CHANNELS];
   logic                       chan_negative   [CHANNELS];
   logic [TIME_W-1:0]          chan_start      [CHANNELS];
   logic [TIME_W-1:0]          chan_peak_time  [CHANNELS];
   logic signed [SAMPLE_W-1:0] chan_peak_value [CHANNELS];
   logic [THR_W-1:0]           chan_threshold  [CHANNELS];
   logic [MASK_W-1:0]          report_mask;

   detector_item_type input_backlog[$];
   spike_rec_type     expected_records[$];
   detector_item_type on_offer;
   spike_rec_type     next_record;

   // Stimulus bookkeeping: the threshold level that the generator last wrote per channel.
   int unsigned    level_of    [CHANNELS];
   bit             level_known [CHANNELS];
   logic [TIME_W-1:0] stamp_now;
   int unsigned    items_queued;

   int unsigned fault_count;
   int unsigned cycle_count;
   int unsigned send_pause;
   int unsigned hold_left;
   bit          calm;
   bit          pressure_go;
   bit          pressure_done;

   // Applies one accepted item to the predicted state; returns 1 when a record is due.
   function automatic bit track_spike(input detector_item_type it, output spike_rec_type rec);
      logic [CH_W-1:0]            c;
      logic signed [SAMPLE_W-1:0] y;
      longint                     sy;
      logic [63:0]                sq;
      logic [63:0]                thr_wide;
      bit                         grows;
      c = it.channel;
      y = it.sample_value;
      rec = '0;
      if (it.op == OP_THRESHOLD) begin
         chan_threshold[c] = it.threshold;
         return 1'b0;
      end
      sy = longint'(y);
      sq = sy * sy;
      thr_wide = {33'd0, chan_threshold[c]};
      // An idle channel starts a spike once the square rises strictly above its threshold.
      if (!chan_active[c]) begin
         if (sq > thr_wide) begin
            chan_active[c]     = 1'b1;
            chan_negative[c]   = (y < 0);
            chan_start[c]      = it.time_stamp;
            chan_peak_time[c]  = it.time_stamp;
            chan_peak_value[c] = y;
         end
         return 1'b0;
      end
      grows = chan_negative[c] ? (y < chan_peak_value[c]) : (y > chan_peak_value[c]);
      if (grows) begin
         chan_peak_value[c] = y;
         chan_peak_time[c]  = it.time_stamp;
         return 1'b0;
      end
      // The spike ends below 0.7 of the threshold, compared exactly in integers.
      if (10 * sq < 7 * thr_wide) begin
         chan_active[c] = 1'b0;
         if (report_mask[c]) begin
            rec.spike_channel = c;
            rec.peak_time     = chan_peak_time[c];
            rec.spike_width   = it.time_stamp - chan_start[c];
            rec.peak_height   = chan_peak_value[c];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void check_field(string name, logic signed [63:0] want,
                                       logic signed [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fault_count++;
      end
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] signed_sample(bit neg, int unsigned mag);
      int v;
      v = neg ? -int'(mag) : int'(mag);
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic detector_item_type make_item(logic op, logic [CH_W-1:0] c,
                                                   logic signed [SAMPLE_W-1:0] y,
                                                   logic [THR_W-1:0] thr);
      detector_item_type it;
      it.op           = op;
      it.channel      = c;
      it.sample_value = y;
      it.time_stamp   = '0;
      it.threshold    = thr;
      return it;
   endfunction

   task automatic enqueue(input detector_item_type it);
      input_backlog.push_back(it);
      items_queued++;
   endtask

   task automatic offer_item(input logic op, input logic [CH_W-1:0] c,
                             input logic signed [SAMPLE_W-1:0] y,
                             input logic [TIME_W-1:0] stamp, input logic [THR_W-1:0] thr);
      detector_item_type it;
      it = make_item(op, c, y, thr);
      it.time_stamp = stamp;
      enqueue(it);
   endtask

   // One spike on a random channel: quiet samples, a crossing, a body, a fall.
   task automatic build_train(ref detector_item_type train[$]);
      logic [CH_W-1:0] c;
      int unsigned     lvl;
      int unsigned     low_mag;
      int unsigned     top;
      int unsigned     mag;
      int unsigned     peak_mag;
      bit              neg;
      c   = CH_W'($urandom_range(0, CHANNELS - 1));
      neg = 1'($urandom_range(0, 1));
      if (!level_known[c] || $urandom_range(0, 4) == 0) begin
         level_of[c]    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32000)
                                                       : $urandom_range(1, 2000);
         level_known[c] = 1'b1;
         train.push_back(make_item(OP_THRESHOLD, c, 16'($urandom()),
                                   THR_W'(level_of[c] * level_of[c])));
      end
      lvl     = level_of[c];
      low_mag = lvl * 8 / 10;
      top     = neg ? 32768 : 32767;
      repeat ($urandom_range(0, 2))
         train.push_back(make_item(OP_SAMPLE, c,
                                   signed_sample(1'($urandom_range(0, 1)),
                                                 $urandom_range(0, low_mag)),
                                   31'($urandom())));
      peak_mag = $urandom_range(lvl + 1, top);
      train.push_back(make_item(OP_SAMPLE, c, signed_sample(neg, peak_mag), 31'($urandom())));
      // Body: new extremes, repeats of the extreme and smaller values above 0.8 of the level.
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(0, 4) == 0)
            mag = peak_mag;
         else
            mag = $urandom_range(low_mag + 1, top);
         if (mag > peak_mag)
            peak_mag = mag;
         train.push_back(make_item(OP_SAMPLE, c, signed_sample(neg, mag), 31'($urandom())));
      end
      mag = $urandom_range(0, low_mag);
      train.push_back(make_item(OP_SAMPLE, c, signed_sample(neg, mag), 31'($urandom())));
   endtask

   // Two interleaved spike trains, sometimes preceded by unrelated noise items.
   task automatic add_random_group();
      detector_item_type first[$];
      detector_item_type second[$];
      detector_item_type it;
      if ($urandom_range(0, 7) == 0)
         stamp_now = $urandom();
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 2)) begin
            it = make_item(1'($urandom_range(0, 1)), CH_W'($urandom_range(0, CHANNELS - 1)),
                           16'($urandom()), 31'($urandom()));
            it.time_stamp = $urandom();
            if (it.op == OP_THRESHOLD)
               level_known[it.channel] = 1'b0;
            enqueue(it);
         end
      end
      build_train(first);
      build_train(second);
      while (first.size() > 0 || second.size() > 0) begin
         if (second.size() == 0 || (first.size() > 0 && $urandom_range(0, 1) == 1))
            it = first.pop_front();
         else
            it = second.pop_front();
         it.time_stamp = stamp_now;
         stamp_now += $urandom_range(1, 3);
         enqueue(it);
      end
   endtask

   task automatic fill_random(input int unsigned count);
      int unsigned target;
      target = items_queued + count;
      while (items_queued < target)
         add_random_group();
   endtask

   // Sampled on the falling edge so that the edge's updates have all settled.
   task automatic wait_until_idle();
      do @(negedge clock);
      while (input_backlog.size() != 0 || req_chan.valid || expected_records.size() != 0);
   endtask

   task automatic write_report_mask(input logic [MASK_W-1:0] value);
      wait_until_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= value;
      do @(posedge clock);
      while (!csr_chan.ready);
      report_mask = value;
      csr_chan.valid <= 1'b0;
   endtask

   // Driver: offers backlog items, holds each until accepted, pauses in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_pause = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            if (track_spike(on_offer, next_record))
               expected_records.push_back(next_record);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (send_pause == 0 && !calm && $urandom_range(0, 9) == 0)
               send_pause = $urandom_range(1, 10);
            if (send_pause > 0) begin
               send_pause--;
               req_chan.valid <= 1'b0;
            end else if (input_backlog.size() > 0) begin
               on_offer = input_backlog.pop_front();
               req_chan.valid                <= 1'b1;
               req_chan.op                   <= on_offer.op;
               req_chan.channel              <= on_offer.channel;
               req_chan.sample_value         <= on_offer.sample_value;
               req_chan.time_stamp           <= on_offer.time_stamp;
               req_chan.threshold_squared_in <= on_offer.threshold;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted record and stalls the result side now and then.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_records.size() == 0) begin
               $error("spike_channel: no record expected, got %0d", rsp_chan.spike_channel);
               fault_count++;
            end else begin
               next_record = expected_records.pop_front();
               check_field("spike_channel", 64'(next_record.spike_channel),
                           64'(rsp_chan.spike_channel));
               check_field("peak_time", 64'(next_record.peak_time), 64'(rsp_chan.peak_time));
               check_field("spike_width", 64'(next_record.spike_width),
                           64'(rsp_chan.spike_width));
               check_field("peak_height", 64'(next_record.peak_height),
                           64'(rsp_chan.peak_height));
            end
         end
         if (hold_left == 0 && !calm && $urandom_range(0, 7) == 0)
            hold_left = $urandom_range(1, 10);
         // One long hold-off lets the block fill up and stall its input.
         if (pressure_go && !pressure_done) begin
            pressure_done = 1'b1;
            hold_left = PRESSURE_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_spike_threshold_detector: errors");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_chan.valid                = 1'b0;
      req_chan.op                   = OP_SAMPLE;
      req_chan.channel              = '0;
      req_chan.sample_value         = '0;
      req_chan.time_stamp           = '0;
      req_chan.threshold_squared_in = '0;
      rsp_chan.ready                = 1'b0;
      csr_chan.valid                = 1'b0;
      csr_chan.data                 = '0;
      report_mask = MASK_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
         chan_active[c]     = 1'b0;
         chan_negative[c]   = 1'b0;
         chan_start[c]      = '0;
         chan_peak_time[c]  = '0;
         chan_peak_value[c] = '0;
         chan_threshold[c]  = THR_MAX;
      end
      stamp_now = $urandom();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Positive spike across the time stamp wrap; a square equal to the threshold
      // does not trigger, and a repeat of the extreme does not move it.
      offer_item(OP_THRESHOLD, 5, 0, 0, 31'd10000);
      offer_item(OP_SAMPLE, 5, 50, 32'hFFFF_FFFC, 0);
      offer_item(OP_SAMPLE, 5, 100, 32'hFFFF_FFFD, 0);
      offer_item(OP_SAMPLE, 5, 101, 32'hFFFF_FFFE, 0);
      offer_item(OP_SAMPLE, 5, 200, 32'hFFFF_FFFF, 0);
      offer_item(OP_SAMPLE, 5, 200, 32'h0000_0001, 0);
      offer_item(OP_SAMPLE, 5, 84, 32'h0000_0002, 0);
      offer_item(OP_SAMPLE, 5, 83, 32'h0000_0003, 0);
      // Negative spike at the sample extremes on the last channel.
      offer_item(OP_THRESHOLD, 63, 0, 0, 31'h3FFF_FFFF);
      offer_item(OP_SAMPLE, 63, 32767, 100, 0);
      offer_item(OP_SAMPLE, 63, -32768, 101, 0);
      offer_item(OP_SAMPLE, 63, 32767, 102, 0);
      offer_item(OP_SAMPLE, 63, -32768, 103, 0);
      offer_item(OP_SAMPLE, 63, 0, 110, 0);
      // A zero threshold: zero never triggers, and a spike can never end.
      offer_item(OP_THRESHOLD, 0, 0, 0, 31'd0);
      offer_item(OP_SAMPLE, 0, 0, 200, 0);
      offer_item(OP_SAMPLE, 0, -1, 201, 0);
      offer_item(OP_SAMPLE, 0, 0, 202, 0);
      // Threshold raised in the middle of a spike: a repeat of the extreme then ends it.
      offer_item(OP_THRESHOLD, 10, 0, 0, 31'd400);
      offer_item(OP_SAMPLE, 10, -30, 300, 0);
      offer_item(OP_SAMPLE, 10, -35, 301, 0);
      offer_item(OP_THRESHOLD, 10, 0, 0, THR_MAX);
      offer_item(OP_SAMPLE, 10, -35, 305, 0);

      // A spike on a masked channel ends silently; its neighbor still reports.
      write_report_mask(~(64'd1 << 7));
      offer_item(OP_THRESHOLD, 7, 0, 0, 31'd100);
      offer_item(OP_SAMPLE, 7, -50, 400, 0);
      offer_item(OP_SAMPLE, 7, 3, 402, 0);
      offer_item(OP_THRESHOLD, 8, 0, 0, 31'd100);
      offer_item(OP_SAMPLE, 8, 50, 410, 0);
      offer_item(OP_SAMPLE, 8, -3, 412, 0);

      write_report_mask('0);
      fill_random(50);
      write_report_mask({$urandom(), $urandom()});
      fill_random(200);
      write_report_mask(MASK_RESET);
      pressure_go = 1'b1;
      fill_random(200);
      write_report_mask(64'hAAAA_AAAA_AAAA_AAAA);
      fill_random(100);
      write_report_mask(MASK_RESET);
      calm = 1'b1;
      fill_random(100);

      wait_until_idle();
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      if (fault_count == 0)
         $display("tb_spike_threshold_detector: clean");
      else
         $display("tb_spike_threshold_detector: errors");
      $finish;
   end

endmodule
